@@ sv/xrng_pkg.sv @@
// xrng_pkg: opcodes, constants and sequencer state type for the xoroshiro128+ unit
// no dependencies; used by the interfaces and the top unit

package xrng_pkg;

  localparam int unsigned OP_W = 3;

  localparam logic [OP_W-1:0] OP_SEED  = 3'd0;
  localparam logic [OP_W-1:0] OP_RAW   = 3'd1;
  localparam logic [OP_W-1:0] OP_MOD8  = 3'd2;
  localparam logic [OP_W-1:0] OP_MOD16 = 3'd3;
  localparam logic [OP_W-1:0] OP_MOD32 = 3'd4;
  localparam logic [OP_W-1:0] OP_RANGE = 3'd5;
  localparam logic [OP_W-1:0] OP_COIN  = 3'd6;

  localparam logic [63:0] GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_C1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_C2  = 64'h94D0_49BB_1331_11EB;

  localparam logic [31:0] DIV_MOD8  = 32'h0000_00FF;
  localparam logic [31:0] DIV_MOD16 = 32'h0000_FFFF;
  localparam logic [31:0] DIV_MOD32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_A,
    ST_MUL1,
    ST_MIX_B,
    ST_MUL2,
    ST_MIX_C,
    ST_DIV,
    ST_FINISH
  } state_t;

  // start strobes from the sequencer to the shared units
  typedef struct packed {
    logic mul_start;
    logic div_start;
  } unit_ctl_t;

endpackage

@@ sv/xrng_if.sv @@
// xrng_in_if / xrng_out_if: valid-ready channels for request and result words
// depends on xrng_pkg for the opcode width

interface xrng_in_if;
  logic                           valid;
  logic                           ready;
  logic [xrng_pkg::OP_W-1:0]      opcode;
  logic [31:0]                    seed_value;
  logic signed [31:0]             range_min;
  logic signed [31:0]             range_max;

  modport source (output valid, opcode, seed_value, range_min, range_max, input ready);
  modport sink   (input valid, opcode, seed_value, range_min, range_max, output ready);
endinterface

interface xrng_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        raw_value;
  logic signed [31:0] ranged_value;

  modport source (output valid, raw_value, ranged_value, input ready);
  modport sink   (input valid, raw_value, ranged_value, output ready);
endinterface

@@ sv/xoroshiro128plus_rng_unit.sv @@
// xoroshiro128plus_rng_unit: xoroshiro128+ generator with splitmix64 seeding
// depends on xrng_pkg, xrng_if, xrng_mul, xrng_div
// path from accept to result valid: raw, coin, unused opcode and empty range go straight to finish,
// seed runs four multiplies, mod and range use the 64-step shared remainder unit
// one word in flight: next word taken in the cycle after the result loads
// reset: synchronous, both state words cleared to zero, no result pending, request held off

module xoroshiro128plus_rng_unit (
  input  logic clk,
  input  logic rst,
  xrng_in_if.sink    req,
  xrng_out_if.source rsp
);

  xrng_pkg::state_t    state, state_next;
  xrng_pkg::unit_ctl_t ctl;

  // generator state
  logic [63:0] word_a;
  logic [63:0] word_b;

  // per-word context
  logic [xrng_pkg::OP_W-1:0] op;
  logic signed [31:0]        lo;
  logic                      bad_span;
  logic [63:0]               sum;
  logic [63:0]               mix_s;
  logic                      second;

  // output register
  logic               out_valid;
  logic [63:0]        out_raw;
  logic signed [31:0] out_ranged;

  // shared units
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_prod;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [31:0] div_rem;

  // combinational helpers
  logic        accept;
  logic        load_out;
  logic [63:0] cur_sum;
  logic [63:0] t_xor;
  logic [63:0] adv_a;
  logic [63:0] adv_b;
  logic [31:0] span;
  logic        span_bad;
  logic        do_adv;
  logic [63:0] mix_fin;
  logic [63:0] res_raw;
  logic [31:0] res_ranged;

  // no word is taken while reset is held
  assign req.ready = (state == xrng_pkg::ST_IDLE) && !rst;
  assign accept    = req.valid && req.ready;

  // xoroshiro128+ advance from the current words
  assign cur_sum = word_a + word_b;
  assign t_xor   = word_a ^ word_b;
  assign adv_a   = {word_a[8:0], word_a[63:9]} ^ t_xor ^ {t_xor[49:0], 14'd0};
  assign adv_b   = {t_xor[27:0], t_xor[63:28]};

  // span with 32-bit wrap, not positive means no draw
  assign span     = 32'(req.range_max) - 32'(req.range_min) + 32'd1;
  assign span_bad = (span == 32'd0) || span[31];

  assign mix_fin = mul_prod ^ {31'd0, mul_prod[63:31]};

  // divisor select from the incoming opcode
  always_comb begin
    unique case (req.opcode)
      xrng_pkg::OP_MOD8:  div_divisor = xrng_pkg::DIV_MOD8;
      xrng_pkg::OP_MOD16: div_divisor = xrng_pkg::DIV_MOD16;
      xrng_pkg::OP_MOD32: div_divisor = xrng_pkg::DIV_MOD32;
      default:            div_divisor = span;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      xrng_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.opcode) inside
            xrng_pkg::OP_SEED: state_next = xrng_pkg::ST_MIX_A;
            xrng_pkg::OP_MOD8,
            xrng_pkg::OP_MOD16,
            xrng_pkg::OP_MOD32: state_next = xrng_pkg::ST_DIV;
            xrng_pkg::OP_RANGE: begin
              state_next = span_bad ? xrng_pkg::ST_FINISH : xrng_pkg::ST_DIV;
            end
            default: state_next = xrng_pkg::ST_FINISH;
          endcase
        end
      end
      xrng_pkg::ST_MIX_A: state_next = xrng_pkg::ST_MUL1;
      xrng_pkg::ST_MUL1:  if (mul_done) state_next = xrng_pkg::ST_MIX_B;
      xrng_pkg::ST_MIX_B: state_next = xrng_pkg::ST_MUL2;
      xrng_pkg::ST_MUL2:  if (mul_done) state_next = xrng_pkg::ST_MIX_C;
      xrng_pkg::ST_MIX_C: state_next = second ? xrng_pkg::ST_FINISH : xrng_pkg::ST_MIX_A;
      xrng_pkg::ST_DIV:   if (div_done) state_next = xrng_pkg::ST_FINISH;
      xrng_pkg::ST_FINISH: if (load_out) state_next = xrng_pkg::ST_IDLE;
      default: state_next = xrng_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl      = '0;
    do_adv   = 1'b0;
    load_out = 1'b0;
    mul_a    = mix_s ^ {30'd0, mix_s[63:30]};
    mul_b    = xrng_pkg::MIX_C1;
    unique case (state)
      xrng_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.opcode) inside
            xrng_pkg::OP_RAW,
            xrng_pkg::OP_COIN: do_adv = 1'b1;
            xrng_pkg::OP_MOD8,
            xrng_pkg::OP_MOD16,
            xrng_pkg::OP_MOD32: begin
              do_adv        = 1'b1;
              ctl.div_start = 1'b1;
            end
            xrng_pkg::OP_RANGE: begin
              do_adv        = ~span_bad;
              ctl.div_start = ~span_bad;
            end
            default: do_adv = 1'b0;
          endcase
        end
      end
      xrng_pkg::ST_MIX_A: ctl.mul_start = 1'b1;
      xrng_pkg::ST_MIX_B: begin
        ctl.mul_start = 1'b1;
        mul_a         = mul_prod ^ {27'd0, mul_prod[63:27]};
        mul_b         = xrng_pkg::MIX_C2;
      end
      xrng_pkg::ST_FINISH: load_out = !out_valid || rsp.ready;
      default: ctl = '0;
    endcase
  end

  // result word assembled from the captured sum and the remainder
  always_comb begin
    res_raw    = '0;
    res_ranged = '0;
    unique case (op) inside
      xrng_pkg::OP_RAW:   res_raw = sum;
      xrng_pkg::OP_COIN:  res_raw = {63'd0, sum[0]};
      xrng_pkg::OP_MOD8,
      xrng_pkg::OP_MOD16,
      xrng_pkg::OP_MOD32: res_raw = {32'd0, div_rem};
      xrng_pkg::OP_RANGE: res_ranged = bad_span ? 32'(lo) : 32'(lo) + div_rem;
      default:            res_raw = '0;
    endcase
  end

  xrng_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (ctl.mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  xrng_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (cur_sum),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  // control and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xrng_pkg::ST_IDLE;
      word_a    <= '0;
      word_b    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_adv) begin
        word_a <= adv_a;
        word_b <= adv_b;
      end else if (state == xrng_pkg::ST_MIX_C) begin
        // first splitmix output seeds word_a, second seeds word_b
        if (second) word_b <= mix_fin;
        else        word_a <= mix_fin;
      end
      if (load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // per-word context and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= req.opcode;
      lo       <= req.range_min;
      bad_span <= span_bad;
      sum      <= cur_sum;
      mix_s    <= {32'd0, req.seed_value} + xrng_pkg::GOLDEN;
      second   <= 1'b0;
    end else if (state == xrng_pkg::ST_MIX_C && !second) begin
      mix_s  <= mix_s + xrng_pkg::GOLDEN;
      second <= 1'b1;
    end
    if (load_out) begin
      out_raw    <= res_raw;
      out_ranged <= res_ranged;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.raw_value    = out_raw;
  assign rsp.ranged_value = out_ranged;

endmodule

@@ sv/xrng_mul.sv @@
// xrng_mul: 64x64 multiplier keeping the low 64 bits, one 64x16 digit per cycle
// no package dependencies

module xrng_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] product
);

  logic        busy;
  logic [1:0]  cnt;
  logic [63:0] mcand;
  logic [63:0] mplier;
  logic [63:0] acc;
  logic [63:0] partial;

  assign partial = mcand * {48'd0, mplier[15:0]};
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= a;
      mplier <= b;
    end else if (busy) begin
      acc    <= acc + partial;
      mcand  <= {mcand[47:0], 16'd0};
      mplier <= {16'd0, mplier[63:16]};
    end
  end

endmodule

@@ sv/xrng_div.sv @@
// xrng_div: restoring 64-by-32 remainder unit, one quotient bit per cycle
// no package dependencies

module xrng_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] dvd;
  logic [31:0] dsr;
  logic [31:0] rem;
  logic [32:0] trial;
  logic [33:0] diff;
  logic        fits;

  assign trial     = {rem, dvd[63]};
  assign diff      = {1'b0, trial} - {2'b00, dsr};
  assign fits      = ~diff[33];
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      rem <= fits ? diff[31:0] : trial[31:0];
    end
  end

endmodule
